@@ hw/rtl/l1u8_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Latin-1 to UTF-8 line repair core.
// Byte class masks, the classification result type and the classify function.
// No dependencies.
package l1u8_pkg;

   localparam int BYTE_W = 8;
   localparam int COPY_W = 2;

   localparam logic [BYTE_W-1:0] HIGH_BIT   = 8'h80;
   localparam logic [BYTE_W-1:0] MASK_2     = 8'hc0;
   localparam logic [BYTE_W-1:0] MASK_3     = 8'he0;
   localparam logic [BYTE_W-1:0] MASK_4     = 8'hf0;
   localparam logic [BYTE_W-1:0] MASK_5     = 8'hf8;
   localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hc0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'he0;
   localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hf0;
   localparam logic [BYTE_W-1:0] LOW_KEEP   = 8'hbf;
   localparam logic [1:0]        TOP_BITS   = 2'h3;

   localparam logic [COPY_W-1:0] COPY_LEAD2 = 2'd0;
   localparam logic [COPY_W-1:0] COPY_LEAD3 = 2'd1;
   localparam logic [COPY_W-1:0] COPY_LEAD4 = 2'd2;

   // Outcome of classifying one held byte against its lookahead.
   typedef struct packed {
      logic [1:0][BYTE_W-1:0] bytes;    // bytes[0] goes out first
      logic [1:0]             count;    // 0..2 bytes emitted
      logic                   consumed; // lookahead byte used up
      logic [COPY_W-1:0]      copy;     // verbatim bytes still to follow
   } class_type;

   function automatic class_type classify_byte(input logic [BYTE_W-1:0] b,
                                               input logic [BYTE_W-1:0] n);
      class_type c;
      c = '0;
      if ((b & HIGH_BIT) == '0) begin
         c.bytes[0] = b;
         c.count    = 2'd1;
      end else if ((n & MASK_2) != CONT_CODE) begin
         // Latin-1 byte: widen to a two-byte sequence
         c.bytes[0] = MASK_2 | {6'd0, b[7:6] & TOP_BITS};
         c.bytes[1] = b & LOW_KEEP;
         c.count    = 2'd2;
      end else begin
         c.consumed = 1'b1;
         if ((b & MASK_3) == LEAD2_CODE) begin
            c.bytes = {n, b};
            c.count = 2'd2;
            c.copy  = COPY_LEAD2;
         end else if ((b & MASK_4) == LEAD3_CODE) begin
            c.bytes = {n, b};
            c.count = 2'd2;
            c.copy  = COPY_LEAD3;
         end else if ((b & MASK_5) == LEAD4_CODE) begin
            c.bytes = {n, b};
            c.count = 2'd2;
            c.copy  = COPY_LEAD4;
         end
         // otherwise: stray high byte, both dropped
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/latin1_to_utf8_line_repair_core.sv @@
`timescale 1ns / 1ps
// Latin-1 to UTF-8 line repair core, top level.
// Depends on l1u8_pkg.
//
// Takes the bytes of a text line one per transfer on req_ and returns clean
// UTF-8 on rsp_, one byte per transfer. Each byte outside a verbatim copy
// waits for the next byte of the line, as it is classified with one byte of
// lookahead: ASCII passes, a high byte not followed by a continuation byte
// is widened as Latin-1 to two bytes, a valid 2/3/4-byte lead starts a
// verbatim copy (cut short at line end), any other high byte is dropped
// with the byte after it. On req_line_end the held byte is flushed and the
// last result of the line carries rsp_out_line_end; a line whose last byte
// produces nothing gets one empty result (rsp_byte_valid low, byte 0).
// Flow: a request lands in an input register; once the four-entry result
// buffer is free it is classified into that registered buffer. A byte is
// accepted every cycle while each produces one result and rsp_ready is
// high; a byte with more results keeps the next one in the input register
// until they have left the single result port, and at most one byte leaves
// per cycle. The input register lets a new request be taken while results wait.
module latin1_to_utf8_line_repair_core
   import l1u8_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              req_line_end,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_out_line_end
);

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // line state
   logic [BYTE_W-1:0] held_ff, held_in;
   logic              held_valid_ff, held_valid_in;
   logic [COPY_W-1:0] copy_ff, copy_in;

   // result buffer, entry 0 is on the port
   logic [3:0][BYTE_W-1:0] buf_ff, buf_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic                   marker_ff, marker_in;
   logic                   le_ff, le_in;

   logic req_fire, rsp_fire, buf_free, advance;

   // classification
   class_type         cls, flush;
   logic [1:0][BYTE_W-1:0] a_bytes, f_bytes;
   logic [1:0]        na, nf;
   logic [BYTE_W-1:0] hb_mid;
   logic              hv_mid;
   logic [COPY_W-1:0] copy_mid;
   logic [2:0]        total;
   logic [3:0][BYTE_W-1:0] res;
   logic              marker;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   // buffer can take a new group when empty or its last entry leaves now
   assign buf_free = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_ready);
   assign advance  = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || buf_free;

   assign rsp_valid        = (cnt_ff != 3'd0);
   assign rsp_out_byte     = buf_ff[0];
   assign rsp_byte_valid   = !marker_ff;
   assign rsp_out_line_end = le_ff && (cnt_ff == 3'd1);

   assign cls = classify_byte(held_ff, in_byte_ff);

   always_comb begin
      // step on the new byte
      a_bytes  = '0;
      na       = 2'd0;
      hb_mid   = held_ff;
      hv_mid   = held_valid_ff;
      copy_mid = copy_ff;
      if (copy_ff != '0) begin
         a_bytes[0] = in_byte_ff;
         na         = 2'd1;
         copy_mid   = copy_ff - 2'd1;
      end else if (held_valid_ff) begin
         a_bytes = cls.bytes;
         na      = cls.count;
         if (cls.consumed) begin
            hv_mid   = 1'b0;
            copy_mid = cls.copy;
         end else begin
            hb_mid = in_byte_ff;
            hv_mid = 1'b1;
         end
      end else begin
         hb_mid = in_byte_ff;
         hv_mid = 1'b1;
      end

      // line end: flush the held byte with a zero lookahead
      flush   = classify_byte(hb_mid, '0);
      f_bytes = flush.bytes;
      nf      = (in_last_ff && hv_mid) ? flush.count : 2'd0;
      total   = {1'b0, na} + {1'b0, nf};

      res = '0;
      case (na)
         2'd0: begin
            res[0] = f_bytes[0];
            res[1] = f_bytes[1];
         end
         2'd1: begin
            res[0] = a_bytes[0];
            res[1] = f_bytes[0];
            res[2] = f_bytes[1];
         end
         2'd2: begin
            res[0] = a_bytes[0];
            res[1] = a_bytes[1];
            res[2] = f_bytes[0];
            res[3] = f_bytes[1];
         end
         default: begin
            res = '0;
         end
      endcase

      // empty line tail still needs an end marker, carrying a zero byte
      marker = in_last_ff && (total == 3'd0);
      if (marker) begin
         total = 3'd1;
         res   = '0;
      end

      if (in_last_ff) begin
         held_in       = '0;
         held_valid_in = 1'b0;
         copy_in       = '0;
      end else begin
         held_in       = hb_mid;
         held_valid_in = hv_mid;
         copy_in       = copy_mid;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      buf_in    = {buf_ff[3], buf_ff[3:1]};
      cnt_in    = cnt_ff;
      marker_in = marker_ff;
      le_in     = le_ff;
      if (advance) begin
         buf_in    = res;
         cnt_in    = total;
         marker_in = marker;
         le_in     = in_last_ff;
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         copy_ff       <= '0;
         cnt_ff        <= '0;
         marker_ff     <= 1'b0;
         le_ff         <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         marker_ff   <= marker_in;
         le_ff       <= le_in;
         if (advance) begin
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
            copy_ff       <= copy_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_line_end;
      end
      if (advance || rsp_fire) begin
         buf_ff <= buf_in;
      end
   end

endmodule

@@ hw/rtl/l1u8_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the Latin-1 to UTF-8 line repair core, with bind.
// Depends on l1u8_pkg and latin1_to_utf8_line_repair_core.
module l1u8_checker
   import l1u8_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [BYTE_W-1:0] req_in_byte,
   input logic              req_line_end,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_byte_valid,
   input logic              rsp_out_line_end
);

   // comes out of reset empty and ready
   a_reset_clean: assert property (@(posedge clock)
      $past(reset) |-> (req_ready && !rsp_valid))
      else $error("not empty after reset");

   // empty marker only closes a line
   a_marker_ends_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> rsp_out_line_end)
      else $error("empty result without line end");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_out_byte == '0))
      else $error("empty result carries a byte");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_valid) && $stable(rsp_out_line_end)))
      else $error("stalled result changed");

   // waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_in_byte)
         && $stable(req_line_end)))
      else $error("waiting request changed");

endmodule

bind latin1_to_utf8_line_repair_core l1u8_checker u_l1u8_checker (.*);

@@ tb/sv/line_repair_check_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the Latin-1 to UTF-8 line repair core: byte predictor and result check.
// Depends on l1u8_pkg (byte width only).
package line_repair_check_pkg;
   import l1u8_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              data_valid;
      logic              last;
   } utf8_out_t;

   class line_repair_checker;
      utf8_out_t         pending_bytes[$];
      utf8_out_t         step_bytes[$];
      logic [BYTE_W-1:0] held;
      bit                held_full;
      logic [1:0]        copy_count;
      int                mismatches;

      function new();
         held       = '0;
         held_full  = 1'b0;
         copy_count = '0;
         mismatches = 0;
      endfunction

      function void emit(logic [BYTE_W-1:0] data, logic data_valid);
         utf8_out_t o;
         o.data       = data;
         o.data_valid = data_valid;
         o.last       = 1'b0;
         step_bytes.push_back(o);
      endfunction

      // Decide the held byte b against lookahead n; returns 1 when n is used up.
      function bit classify(logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] n);
         if (!b[7]) begin
            emit(b, 1'b1);
            return 1'b0;
         end
         if (n[7:6] != 2'b10) begin
            // Latin-1: widen to two bytes
            emit({6'b110000, b[7:6]}, 1'b1);
            emit({b[7], 1'b0, b[5:0]}, 1'b1);
            return 1'b0;
         end
         if (b[7:5] == 3'b110) begin
            emit(b, 1'b1);
            emit(n, 1'b1);
            copy_count = 2'd0;
         end else if (b[7:4] == 4'b1110) begin
            emit(b, 1'b1);
            emit(n, 1'b1);
            copy_count = 2'd1;
         end else if (b[7:3] == 5'b11110) begin
            emit(b, 1'b1);
            emit(n, 1'b1);
            copy_count = 2'd2;
         end
         // anything else: stray high byte, pair dropped
         return 1'b1;
      endfunction

      function void note_input(logic [BYTE_W-1:0] x, logic line_end);
         bit        used;
         utf8_out_t tail;
         step_bytes.delete();
         if (copy_count != 0) begin
            emit(x, 1'b1);
            copy_count = copy_count - 2'd1;
         end else if (held_full) begin
            held_full = 1'b0;
            used = classify(held, x);
            if (!used) begin
               held      = x;
               held_full = 1'b1;
            end
         end else begin
            held      = x;
            held_full = 1'b1;
         end
         if (line_end) begin
            if (held_full) begin
               held_full = 1'b0;
               used = classify(held, '0);
            end
            held       = '0;
            copy_count = '0;
            if (step_bytes.size() == 0)
               emit('0, 1'b0);
            tail = step_bytes.pop_back();
            tail.last = 1'b1;
            step_bytes.push_back(tail);
         end
         foreach (step_bytes[i])
            pending_bytes.push_back(step_bytes[i]);
      endfunction

      function void check_result(logic [BYTE_W-1:0] data, logic data_valid, logic last);
         utf8_out_t exp_o;
         if (pending_bytes.size() == 0) begin
            $error("unexpected result: out_byte %h byte_valid %b out_line_end %b",
                   data, data_valid, last);
            mismatches++;
            return;
         end
         exp_o = pending_bytes.pop_front();
         if (data !== exp_o.data) begin
            $error("out_byte: expected %h, actual %h", exp_o.data, data);
            mismatches++;
         end
         if (data_valid !== exp_o.data_valid) begin
            $error("byte_valid: expected %b, actual %b", exp_o.data_valid, data_valid);
            mismatches++;
         end
         if (last !== exp_o.last) begin
            $error("out_line_end: expected %b, actual %b", exp_o.last, last);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_bytes.size();
      endfunction
   endclass

endpackage

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for latin1_to_utf8_line_repair_core: directed and random text lines.
// Depends on l1u8_pkg, line_repair_check_pkg and the core RTL.
module tb;
   import l1u8_pkg::*;
   import line_repair_check_pkg::*;

   localparam int RANDOM_ITEMS = 280;
   localparam int STALL_LIMIT  = 2000;  // cycles without any transfer
   localparam int DRAIN_CYCLES = 10;

   // Directed bytes, bit 8 marks the last byte of a line.
   localparam logic [8:0] DIRECTED_BYTES [24] = '{
      9'h141,                             // single ASCII byte line
      9'h000, 9'h07F, 9'h0E9, 9'h141,     // zero byte, DEL, Latin-1 before ASCII
      9'h1FF,                             // Latin-1 flushed at line end
      9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h1AC, // 2- and 3-byte characters
      9'h0F0, 9'h09F, 9'h098, 9'h180,     // 4-byte character
      9'h0F0, 9'h09F, 9'h198,             // 4-byte copy cut by line end
      9'h080, 9'h180,                     // dropped pair, empty end marker
      9'h0F8, 9'h080, 9'h0C3, 9'h141      // bad lead dropped, lead without continuation
   };

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [BYTE_W-1:0] req_in_byte;
   logic              req_line_end;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_byte_valid;
   logic              rsp_out_line_end;

   line_repair_checker repair_chk;
   bit                 calm;        // no new idle gaps on either side while set
   int                 rsp_stall;
   int                 quiet_cycles;
   int                 bytes_sent;

   latin1_to_utf8_line_repair_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_out_line_end (rsp_out_line_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, a few long ones; none at all during calm stretches.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Result side: ready drops for random stretches, driven at the falling edge.
   initial begin
      rsp_ready = 1'b0;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 30)
               rsp_stall = idle_len();
         end
      end
   end

   // Monitor: both channels sampled at the rising edge. Results are checked
   // before the input transfer of the same edge is noted; a byte accepted now
   // cannot have a result out yet, so the order is harmless either way.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            repair_chk.check_result(rsp_out_byte, rsp_byte_valid, rsp_out_line_end);
         if (req_valid && req_ready)
            repair_chk.note_input(req_in_byte, req_line_end);
      end
   end

   // Watchdog: ends the run when no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   // Valid stays high from one byte to the next when there is no gap, so it
   // gets a single assignment per time step.
   task automatic send_byte(input logic [BYTE_W-1:0] x, input logic last);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_in_byte  <= x;
      req_line_end <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Random line: mostly well-formed pieces (ASCII, Latin-1, 2/3/4-byte
   // characters), some stray continuations and noise. The tail is cut at the
   // target length, which often leaves a character unfinished at line end.
   task automatic send_random_line();
      logic [BYTE_W-1:0] line_q[$];
      int                target;
      int                kind;
      int                conts;
      target = $urandom_range(1, 12);
      while (line_q.size() < target) begin
         kind  = $urandom_range(0, 9);
         conts = 0;
         case (kind)
            0, 1, 2, 3: line_q.push_back(8'($urandom_range(0, 127)));
            4: line_q.push_back(8'($urandom_range(128, 255)));
            5: begin
               line_q.push_back({3'b110, 5'($urandom)});
               conts = 1;
            end
            6: begin
               line_q.push_back({4'b1110, 4'($urandom)});
               conts = 2;
            end
            7: begin
               line_q.push_back({5'b11110, 3'($urandom)});
               conts = 3;
            end
            8: line_q.push_back(8'($urandom));
            default: line_q.push_back({2'b10, 6'($urandom)});
         endcase
         repeat (conts) line_q.push_back({2'b10, 6'($urandom)});
      end
      while (line_q.size() > target) void'(line_q.pop_back());
      foreach (line_q[i])
         send_byte(line_q[i], i == line_q.size() - 1);
   endtask

   initial begin
      req_valid    = 1'b0;
      req_in_byte  = '0;
      req_line_end = 1'b0;
      reset        = 1'b1;
      calm         = 1'b0;
      quiet_cycles = 0;
      bytes_sent   = 0;
      repair_chk   = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_BYTES[i])
         send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);

      bytes_sent = 0;
      while (bytes_sent < RANDOM_ITEMS) begin
         // toggle calm stretches now and then so both idle and busy phases occur
         if ($urandom_range(0, 9) == 0)
            calm = !calm;
         send_random_line();
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // drain: wait for every expected byte, then watch for strays
      while (repair_chk.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (repair_chk.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/l1u8_pkg.sv
hw/rtl/latin1_to_utf8_line_repair_core.sv
hw/rtl/l1u8_checker.sv
tb/sv/line_repair_check_pkg.sv
tb/sv/tb.sv
